// ----- rtl/ppl_pkg.sv -----
// Shared widths, command codes and register indexes of the playback position looper.
package ppl_pkg;

  // Field widths fixed by the stream and configuration formats
  localparam int VAL_W       = 64;
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 63;
  localparam int MODE_W      = 2;
  localparam int DUR_W       = 62;
  localparam int CFG_ADDR_W  = 1;
  localparam int OUT_TDATA_W = 72;

  // Digit width of the serial adder
  localparam int ADD_DIGIT = 8;

  // Bit places inside the result tdata
  localparam int OUT_CHG_BIT = POS_W;
  localparam int OUT_RUN_BIT = POS_W + 1;

  // Command codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_PLAY    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAUSE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 3'd4;

  // Loop modes; the unused code behaves as once
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DURATION  = 1'b1;

endpackage

// ----- rtl/playback_position_looper.sv -----
// Top level of the playback position looper: command sequencer, state and result register.
//
//   channel   direction  handshake              payload
//   in_       slave      in_tvalid / in_tready  tdata value, tuser command
//   out_      master     out_tvalid / out_tready tdata position, changed, running
//   cfg_      slave      cfg_valid / cfg_ready  cfg_addr index, cfg_data value
//
// Play, pause, stop, set time and an advance that does not act go straight to the result step.
// An advance in once mode passes through the 8-bit digit adder.
// An advance in loop or ping-pong mode passes through the adder and then the
// bit-serial remainder unit, which works one bit of TIME_WIDTH per cycle.
// One command is in work at a time; the next is taken while a result waits.
// Reset (rst_n low, synchronous) zeroes position, playing flag and registers.
// A stalled out_tready holds the finished result and parks the next command in
// its final step; configuration writes are taken in every cycle.
module playback_position_looper #(
  parameter int TIME_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ppl_pkg::VAL_W-1:0]          in_tdata,   // [63:0] value
  input  logic [ppl_pkg::FUNC_W-1:0]         in_tuser,   // [2:0] func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ppl_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [62:0] position, [63] changed,
                                                         // [64] running, [71:65] zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ppl_pkg::DUR_W-1:0]          cfg_data
);

  import ppl_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam logic [VAL_W-1:0] TMAX64 = (VAL_W'(1) << (TW - 1)) - VAL_W'(1);
  localparam logic [VAL_W-1:0] TMIN64 = ~TMAX64;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_CLAMP, S_MAP, S_DIV, S_FIX, S_MIRROR, S_PUB
  } state_t;

  state_t              state_r;
  logic [MODE_W-1:0]   mode_r;
  logic [DUR_W-1:0]    duration_r;
  logic [TW-2:0]       position_r;
  logic                playing_r;
  logic [TW-2:0]       dur_r;
  logic                dsign_r;
  logic [TW-1:0]       next_r;
  logic                neg_r;
  logic [TW-1:0]       period_r;
  logic [TW-1:0]       rem_r;
  logic [TW-2:0]       res_pos_r;
  logic                res_run_r;
  logic                res_adv_r;
  logic                out_tvalid_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_chg_r;
  logic                out_run_r;

  logic                in_accept;
  logic                mode_loop;
  logic                mode_ping;
  logic [VAL_W-1:0]    dur64;
  logic [TW-2:0]       dur_eff;
  logic [TW-2:0]       set_pos;
  logic                adv_acts;
  logic [TW-2:0]       cmd_pos;
  logic                cmd_run;
  logic                cmd_adv;
  logic                add_start;
  logic                add_done;
  logic [VAL_W-1:0]    add_sum;
  logic                sum_ovf;
  logic [TW-1:0]       next_c;
  logic                next_neg;
  logic [TW-1:0]       dur_x;
  logic [TW-1:0]       period_c;
  logic [TW-1:0]       mag_c;
  logic                div_start;
  logic                div_done;
  logic [TW-1:0]       div_rem;
  logic [TW-1:0]       fix_c;
  logic [TW-1:0]       mir_c;
  logic                changed_c;
  logic                pub_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign mode_loop = (mode_r == MODE_LOOP);
  assign mode_ping = (mode_r == MODE_PING);

  // Effective duration: capped at the largest time value
  assign dur64   = VAL_W'(duration_r);
  assign dur_eff = (dur64 > TMAX64) ? TMAX64[TW-2:0] : dur64[TW-2:0];

  // Set time clamps into 0..max
  assign set_pos = in_tdata[VAL_W-1] ? '0 :
                   ($signed(in_tdata) > $signed(TMAX64)) ? TMAX64[TW-2:0] :
                   in_tdata[TW-2:0];

  // An advance acts only while playing with a nonzero delta and duration
  assign adv_acts  = playing_r && (|in_tdata) && (|duration_r);
  assign add_start = in_accept && (in_tuser == FUNC_ADVANCE) && adv_acts;

  // Decode the offered command into its immediate result
  always_comb begin
    cmd_pos = position_r;
    cmd_run = playing_r;
    cmd_adv = 1'b0;
    unique case (in_tuser)
      FUNC_PLAY:  cmd_run = 1'b1;
      FUNC_PAUSE: cmd_run = 1'b0;
      FUNC_STOP: begin
        cmd_run = 1'b0;
        cmd_pos = '0;
      end
      FUNC_SET:     cmd_pos = set_pos;
      FUNC_ADVANCE: cmd_adv = adv_acts;
      default:      cmd_adv = 1'b0;
    endcase
  end

  ppl_sadd #(
    .WIDTH (VAL_W),
    .DIGIT (ADD_DIGIT)
  ) u_sadd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (add_start),
    .a_in  (in_tdata),
    .b_in  (VAL_W'(position_r)),
    .done  (add_done),
    .sum   (add_sum)
  );

  // Saturate the sum, then clamp it into the signed time range
  assign sum_ovf = !dsign_r && add_sum[VAL_W-1];
  always_comb begin
    priority if (sum_ovf || ($signed(add_sum) > $signed(TMAX64))) begin
      next_c = TMAX64[TW-1:0];
    end else if ($signed(add_sum) < $signed(TMIN64)) begin
      next_c = TMIN64[TW-1:0];
    end else begin
      next_c = add_sum[TW-1:0];
    end
  end

  // Divisor and dividend magnitude for the wrap modes
  assign next_neg  = next_r[TW-1];
  assign dur_x     = {1'b0, dur_r};
  assign period_c  = mode_ping ? {dur_r, 1'b0} : dur_x;
  assign mag_c     = next_neg ? (~next_r + TW'(1)) : next_r;
  assign div_start = (state_r == S_MAP) && (mode_loop || mode_ping);

  ppl_srem #(
    .WIDTH (TW)
  ) u_srem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_c),
    .divisor  (period_c),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Floor remainder for negative times, then mirror for ping-pong
  assign fix_c = (neg_r && (|div_rem)) ? (period_r - div_rem) : div_rem;
  assign mir_c = (mode_ping && (rem_r >= dur_x)) ? (period_r - rem_r) : rem_r;

  assign changed_c = res_adv_r && (res_pos_r != position_r);
  assign pub_load  = (state_r == S_PUB) && (!out_tvalid_r || out_tready);

  // Sequencer, architectural state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_ONCE;
      duration_r   <= '0;
      position_r   <= '0;
      playing_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_LOOP_MODE: mode_r     <= cfg_data[MODE_W-1:0];
          REG_DURATION:  duration_r <= cfg_data;
          default:       mode_r     <= mode_r;
        endcase
      end

      // Raise a new result, drop it once its transaction completes
      if (pub_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            dur_r     <= dur_eff;
            dsign_r   <= in_tdata[VAL_W-1];
            res_pos_r <= cmd_pos;
            res_run_r <= cmd_run;
            res_adv_r <= cmd_adv;
            state_r   <= cmd_adv ? S_ADD : S_PUB;
          end
        end
        S_ADD: begin
          if (add_done) begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          next_r  <= next_c;
          state_r <= S_MAP;
        end
        S_MAP: begin
          if (mode_loop || mode_ping) begin
            neg_r    <= next_neg;
            period_r <= period_c;
            state_r  <= S_DIV;
          end else begin
            // Once: clamp to 0..duration, stop at either end
            res_run_r <= !(next_neg || (next_r >= dur_x));
            res_pos_r <= next_neg ? '0 : (next_r > dur_x) ? dur_r : next_r[TW-2:0];
            state_r   <= S_PUB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          rem_r   <= fix_c;
          state_r <= S_MIRROR;
        end
        S_MIRROR: begin
          res_pos_r <= mir_c[TW-2:0];
          state_r   <= S_PUB;
        end
        S_PUB: begin
          if (pub_load) begin
            position_r <= res_pos_r;
            playing_r  <= res_run_r;
            out_pos_r  <= POS_W'(res_pos_r);
            out_chg_r  <= changed_c;
            out_run_r  <= res_run_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_run_r, out_chg_r, out_pos_r});

endmodule

// ----- rtl/ppl_sadd.sv -----
// Digit-serial adder: sums two words one digit per cycle through shift registers.
module ppl_sadd #(
  parameter int WIDTH = 64,
  parameter int DIGIT = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  output logic             done,
  output logic [WIDTH-1:0] sum
);

  localparam int STEPS = WIDTH / DIGIT;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [WIDTH-1:0] a_sr_r;
  logic [WIDTH-1:0] b_sr_r;
  logic [WIDTH-1:0] s_sr_r;
  logic             carry_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIGIT:0]   digit_sum;

  // Add the lowest digits with the stored carry
  assign digit_sum = {1'b0, a_sr_r[DIGIT-1:0]} + {1'b0, b_sr_r[DIGIT-1:0]}
                     + (DIGIT + 1)'(carry_r);

  // Load operands, then shift one digit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_sr_r  <= a_in;
        b_sr_r  <= b_in;
        carry_r <= 1'b0;
        cnt_r   <= CNT_W'(STEPS - 1);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        a_sr_r  <= a_sr_r >> DIGIT;
        b_sr_r  <= b_sr_r >> DIGIT;
        s_sr_r  <= {digit_sum[DIGIT-1:0], s_sr_r[WIDTH-1:DIGIT]};
        carry_r <= digit_sum[DIGIT];
        cnt_r   <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign sum  = s_sr_r;

endmodule

// ----- rtl/ppl_srem.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ppl_srem #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] q_sr_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-1:0] r_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [WIDTH:0]   r_shift;
  logic [WIDTH:0]   r_diff;
  logic             r_ge;

  // Bring in the next dividend bit and trial-subtract the divisor
  assign r_shift = {r_r, q_sr_r[WIDTH-1]};
  assign r_diff  = r_shift - {1'b0, d_r};
  assign r_ge    = (r_shift >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_sr_r <= dividend;
        d_r    <= divisor;
        r_r    <= '0;
        cnt_r  <= CNT_W'(WIDTH - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_sr_r <= q_sr_r << 1;
        r_r    <= r_ge ? r_diff[WIDTH-1:0] : r_shift[WIDTH-1:0];
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

// ----- rtl/ppl_checker.sv -----
// Port-level checker of the playback position looper and its bind statement.
module ppl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ppl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);

  import ppl_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Work on one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in work");

  // A new result only follows a command in work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a command in work");

  // Configuration is never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // Padding above the running flag stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:OUT_RUN_BIT+1] == '0))
    else $error("nonzero padding in result");

endmodule

bind playback_position_looper ppl_checker u_ppl_checker (.*);

// ----- dv/playback_position_looper_tb.sv -----
// Self-checking testbench of the playback position looper: directed script, then random phases.
`timescale 1ns / 100ps

module playback_position_looper_tb;
  import ppl_pkg::*;

  localparam int TIME_W = 64;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int STUCK_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [VAL_W-1:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VAL_W-1:0] VAL_ONES = '1;
  localparam logic [POS_W-1:0] POS_ALL = '1;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;
  localparam longint TMAX = 64'sh7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             chg;
    logic             run;
  } status_t;

  typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [FUNC_W-1:0]     func;
    logic [CFG_ADDR_W-1:0] idx;
    logic [VAL_W-1:0]      value;
    bit                    typed;
    status_t               want;
  } script_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [VAL_W-1:0]       in_tdata = '0;     // [63:0] value
  logic [FUNC_W-1:0]      in_tuser = '0;     // [2:0] func
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [62:0] position, [63] changed, [64] running
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [DUR_W-1:0]       cfg_data = '0;

  // Shadow copy of the block state and registers
  logic [POS_W-1:0]  play_pos = '0;
  logic              is_playing = 1'b0;
  logic [MODE_W-1:0] cfg_mode = '0;
  logic [DUR_W-1:0]  cfg_dur = '0;

  status_t     awaited_status[$];
  script_row_t script[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  playback_position_looper #(
    .TIME_WIDTH(TIME_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Advance the shadow state by one command and return the status it leaves
  function automatic status_t apply_command(input logic [FUNC_W-1:0] f,
                                            input logic [VAL_W-1:0] v);
    status_t     r;
    longint      sv;
    longint      cur;
    longint      next;
    longint      dur;
    longint      period;
    longint      m;
    logic [MODE_W-1:0] eff;
    sv = v;
    r.chg = 1'b0;
    case (f)
      FUNC_PLAY:  is_playing = 1'b1;
      FUNC_PAUSE: is_playing = 1'b0;
      FUNC_STOP: begin
        is_playing = 1'b0;
        play_pos = '0;
      end
      FUNC_SET: play_pos = (sv < 0) ? '0 : v[POS_W-1:0];
      FUNC_ADVANCE: begin
        if (is_playing && sv != 0 && cfg_dur != '0) begin
          cur = longint'({1'b0, play_pos});
          dur = longint'({2'b00, cfg_dur});
          // saturate on the way up; a negative delta cannot wrap from a non-negative base
          if (sv > 0 && cur > TMAX - sv) next = TMAX;
          else next = cur + sv;
          eff = (cfg_mode == MODE_SPARE) ? MODE_ONCE : cfg_mode;
          case (eff)
            MODE_LOOP: begin
              m = next % dur;
              if (m < 0) m = m + dur;
            end
            MODE_PING: begin
              period = dur * 2;
              m = next % period;
              if (m < 0) m = m + period;
              if (m >= dur) m = period - m;
            end
            default: begin
              if (next >= dur || next < 0) is_playing = 1'b0;
              m = (next < 0) ? 0 : ((next > dur) ? dur : next);
            end
          endcase
          r.chg = (m != cur);
          play_pos = m[POS_W-1:0];
        end
      end
      default: ;
    endcase
    r.pos = play_pos;
    r.run = is_playing;
    return r;
  endfunction

  function automatic void script_cmd(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v,
                                     input bit typed, input logic [POS_W-1:0] pos,
                                     input logic chg, input logic run);
    script_row_t row;
    row.kind = ROW_CMD;
    row.func = f;
    row.idx = '0;
    row.value = v;
    row.typed = typed;
    row.want = '{pos, chg, run};
    script.insert(script.size(), row);
  endfunction

  function automatic void script_reg(input logic [CFG_ADDR_W-1:0] idx,
                                     input logic [VAL_W-1:0] data);
    script_row_t row;
    row.kind = ROW_REG;
    row.func = '0;
    row.idx = idx;
    row.value = data;
    row.typed = 1'b0;
    row.want = '0;
    script.insert(script.size(), row);
  endfunction

  // Offer one command, hold it until taken, then queue its status
  task automatic send_command(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v,
                              input bit typed, input status_t want);
    status_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tuser <= f;
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = apply_command(f, v);
    awaited_status.insert(awaited_status.size(), typed ? want : predicted);
  endtask

  // Drop the input and wait until every queued status has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [DUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == REG_LOOP_MODE) cfg_mode = data[MODE_W-1:0];
    else cfg_dur = data;
    @(posedge clk);
  endtask

  // Check each result transaction and drive the ready side
  always @(posedge clk) begin
    status_t          want;
    logic [POS_W-1:0] got_pos;
    logic             got_chg;
    logic             got_run;
    if (rst_n && out_tvalid && out_tready) begin
      got_pos = out_tdata[POS_W-1:0];
      got_chg = out_tdata[OUT_CHG_BIT];
      got_run = out_tdata[OUT_RUN_BIT];
      if (awaited_status.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: result with nothing awaited, got position %0d changed %0b running %0b",
                   $time, got_pos, got_chg, got_run);
        errors++;
      end else begin
        want = awaited_status.pop_front();
        if (got_pos !== want.pos || got_chg !== want.chg || got_run !== want.run) begin
          if (errors < REPORT_MAX)
            $display("%0t: expected position %0d changed %0b running %0b, got %0d %0b %0b",
                     $time, want.pos, want.chg, want.run, got_pos, got_chg, got_run);
          errors++;
        end
      end
    end
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [FUNC_W-1:0] f;
    logic [VAL_W-1:0]  v;
    logic [VAL_W-1:0]  span;
    logic [VAL_W-1:0]  mag;
    logic [MODE_W-1:0] mode_sel;
    logic [DUR_W-1:0]  dur_sel;
    int                sel;

    // Directed script: commands before reaching any duration, once-mode ends,
    // saturation, unknown commands, the spare loop mode, loop and ping-pong edges
    script_cmd(FUNC_STOP, '0, 1'b1, '0, 1'b0, 1'b0);
    script_cmd(FUNC_PLAY, '0, 1'b1, '0, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, 64'd5, 1'b1, '0, 1'b0, 1'b1);
    script_reg(REG_DURATION, 64'd1000);
    script_reg(REG_LOOP_MODE, VAL_W'(MODE_ONCE));
    script_cmd(FUNC_ADVANCE, '0, 1'b1, '0, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, 64'd300, 1'b1, 63'd300, 1'b1, 1'b1);
    script_cmd(FUNC_ADVANCE, 64'd2000, 1'b1, 63'd1000, 1'b1, 1'b0);
    script_cmd(FUNC_ADVANCE, 64'd5, 1'b1, 63'd1000, 1'b0, 1'b0);
    script_cmd(FUNC_SET, -64'sd7, 1'b1, '0, 1'b0, 1'b0);
    script_cmd(FUNC_SET, VAL_MAX, 1'b1, POS_ALL, 1'b0, 1'b0);
    script_cmd(FUNC_PLAY, '0, 1'b1, POS_ALL, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, VAL_MAX, 1'b1, 63'd1000, 1'b1, 1'b0);
    script_cmd(FUNC_UNUSED_LO, 64'h0123_4567_89ab_cdef, 1'b1, 63'd1000, 1'b0, 1'b0);
    script_cmd(FUNC_UNUSED_HI, VAL_ONES, 1'b1, 63'd1000, 1'b0, 1'b0);
    script_reg(REG_LOOP_MODE, VAL_W'(MODE_SPARE));
    script_cmd(FUNC_PLAY, '0, 1'b1, 63'd1000, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, VAL_MIN, 1'b1, '0, 1'b1, 1'b0);
    script_reg(REG_LOOP_MODE, VAL_W'(MODE_LOOP));
    script_reg(REG_DURATION, VAL_W'(DUR_MAX));
    script_cmd(FUNC_PLAY, '0, 1'b1, '0, 1'b0, 1'b1);
    script_cmd(FUNC_SET, VAL_MAX, 1'b1, POS_ALL, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, VAL_MAX, 1'b0, '0, 1'b0, 1'b0);
    script_cmd(FUNC_ADVANCE, VAL_MIN, 1'b0, '0, 1'b0, 1'b0);
    script_reg(REG_LOOP_MODE, VAL_W'(MODE_PING));
    script_reg(REG_DURATION, 64'd1000);
    script_cmd(FUNC_SET, 64'd999, 1'b1, 63'd999, 1'b0, 1'b1);
    script_cmd(FUNC_ADVANCE, 64'd1, 1'b0, '0, 1'b0, 1'b0);
    script_cmd(FUNC_ADVANCE, 64'd1, 1'b0, '0, 1'b0, 1'b0);
    script_cmd(FUNC_ADVANCE, -64'sd2000, 1'b0, '0, 1'b0, 1'b0);
    script_cmd(FUNC_PAUSE, '0, 1'b0, '0, 1'b0, 1'b0);
    script_cmd(FUNC_ADVANCE, 64'd5, 1'b0, '0, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle();
        write_register(script[i].idx, script[i].value[DUR_W-1:0]);
      end else begin
        send_command(script[i].func, script[i].value, script[i].typed, script[i].want);
      end
    end

    // Random phases, each with its own register setting and idling profile
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:  begin mode_sel = MODE_LOOP;  dur_sel = 62'd1000; end
        1:  begin mode_sel = MODE_PING;  dur_sel = 62'd1000; end
        2:  begin mode_sel = MODE_ONCE;  dur_sel = 62'd1000; end
        3:  begin mode_sel = MODE_LOOP;  dur_sel = 62'd1; end
        4:  begin mode_sel = MODE_PING;  dur_sel = 62'd1; end
        5:  begin mode_sel = MODE_ONCE;  dur_sel = DUR_MAX; end
        6:  begin mode_sel = MODE_LOOP;  dur_sel = DUR_W'(rand64()); end
        7:  begin mode_sel = MODE_PING;  dur_sel = DUR_MAX; end
        8:  begin mode_sel = MODE_SPARE; dur_sel = 62'd50; end
        9:  begin mode_sel = MODE_LOOP;  dur_sel = '0; end
        10: begin mode_sel = MODE_PING;  dur_sel = DUR_W'($urandom_range(100, 1)); end
        default: begin mode_sel = MODE_LOOP; dur_sel = DUR_W'($urandom_range(5000, 1)); end
      endcase
      // upper bits of the mode write are don't-care and get random content
      write_register(REG_LOOP_MODE, DUR_W'({rand64(), mode_sel}));
      write_register(REG_DURATION, dur_sel);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      span = ({2'b00, cfg_dur} << 1) + 64'd2;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold while commands keep coming, and one full pause of the sender
        if (p == 2 && n == 40) hold_request = LONG_HOLD;
        if (p == 5 && n == 60) settle();

        sel = $urandom_range(99);
        if (sel < 62 || sel >= 94) begin
          f = (sel >= 50 && sel < 62) ? FUNC_SET : FUNC_ADVANCE;
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
              mag = rand64() % span;
              v = $urandom_range(1) ? -mag : mag;
            end
            6: v = rand64();
            7: begin
              case ($urandom_range(4))
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = 64'd1;
                3: v = VAL_ONES;
                default: v = '0;
              endcase
            end
            default: begin
              mag = VAL_W'($urandom_range(20));
              v = $urandom_range(1) ? -mag : mag;
            end
          endcase
        end else begin
          if (sel < 78) f = FUNC_PLAY;
          else if (sel < 84) f = FUNC_PAUSE;
          else if (sel < 89) f = FUNC_STOP;
          else f = FUNC_W'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
          v = rand64();
        end
        send_command(f, v, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
